### rtl/core/servo_velocity_with_speed_cap_unit_macros.svh
// assertion macros used by the checker file
`ifndef SERVO_VELOCITY_WITH_SPEED_CAP_UNIT_MACROS_SVH
`define SERVO_VELOCITY_WITH_SPEED_CAP_UNIT_MACROS_SVH

// same-cycle implication
`define SVC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// implication after a fixed number of cycles
`define SVC_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

### rtl/core/svc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svc_pkg
// Shared constants of the servo velocity unit: register codes, step counts
// of the iterative units and the item latency.
// ----------------------------------------------------------------------------
package svc_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Z = 3'd4;

    localparam logic [31:0] GAIN_RST = 32'h0001_0000;
    localparam logic [31:0] CAP_RST  = 32'h0001_0000;

    localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

    // quotient bits of the rotation divider, root bits, quotient bits of the cap divider
    localparam int ROT_STEPS  = 31;
    localparam int SQRT_STEPS = 32;
    localparam int CAP_STEPS  = 32;

    // 4 front stages, 14 middle stages, 2 before the cap divider, 1 output stage
    localparam int LATENCY = 4 + ROT_STEPS + 14 + SQRT_STEPS + 2 + CAP_STEPS + 1;

endpackage

### rtl/core/servo_velocity_with_speed_cap_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_velocity_with_speed_cap_unit
// Visual servo velocity: rotated gripper offset, gained error, speed cap.
// ----------------------------------------------------------------------------
// An item is taken on every clock edge with start high and busy low; busy is
// a register set in reset and cleared once reset is released, so one item
// can enter each cycle from then on. Every item gives one result, shown for
// one cycle with o_valid; the receiver cannot stall and need not. The
// pipeline holds three bit-serial units: the divider that forms the rotation
// matrix (31 stages), the square root of the rescale (32 stages) and the
// rescale divider (32 stages), plus 21 arithmetic stages. Configuration writes
// are always taken (o_cfg_ready is high) and must only come with no item in
// flight.
module servo_velocity_with_speed_cap_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [svc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                       i_cfg_data,
    input  logic signed [31:0]                i_marker_x,
    input  logic signed [31:0]                i_marker_y,
    input  logic signed [31:0]                i_marker_z,
    input  logic signed [15:0]                i_quat_w,
    input  logic signed [15:0]                i_quat_x,
    input  logic signed [15:0]                i_quat_y,
    input  logic signed [15:0]                i_quat_z,
    input  logic signed [31:0]                i_target_x,
    input  logic signed [31:0]                i_target_y,
    input  logic signed [31:0]                i_target_z,
    output logic                              o_valid,
    output logic signed [31:0]                o_vel_x,
    output logic signed [31:0]                o_vel_y,
    output logic signed [31:0]                o_vel_z,
    output logic                              o_capped
);
    import svc_pkg::*;

    typedef struct packed {
        logic [2:0][31:0] mk;
        logic [2:0][31:0] tg;
    } t_pos;

    typedef struct packed {
        t_pos        pos;
        logic [8:0]  neg;
        logic        ident;
        logic [32:0] n;
    } t_rot_side;

    typedef struct packed {
        logic [2:0][31:0] s32;
        logic [2:0]       neg;
        logic             capped;
    } t_tail;

    typedef struct packed {
        logic [2:0][30:0] r;
        t_tail            tail;
    } t_sq_side;

    typedef struct packed {
        logic [31:0] m;
        t_tail       tail;
    } t_cd_side;

    // ------------------------------------------------------------------
    // configuration and control
    // ------------------------------------------------------------------
    logic [31:0]        r_gain;
    logic [31:0]        r_cap;
    logic signed [31:0] r_off [3];
    logic               r_busy;
    logic [LATENCY-1:0] r_vld;
    logic               w_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RST;
            r_cap  <= CAP_RST;
            r_off[0] <= '0;
            r_off[1] <= '0;
            r_off[2] <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GAIN:  r_gain   <= i_cfg_data;
                REG_CAP:   r_cap    <= i_cfg_data;
                REG_OFF_X: r_off[0] <= i_cfg_data;
                REG_OFF_Y: r_off[1] <= i_cfg_data;
                REG_OFF_Z: r_off[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = r_busy;
    assign w_acc       = start & ~r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[LATENCY-2:0], w_acc};
        end
    end

    assign o_valid = r_vld[LATENCY-1];

    // ------------------------------------------------------------------
    // stage 1: quaternion products
    // ------------------------------------------------------------------
    logic signed [31:0] n1_sq [4];
    logic signed [31:0] n1_cr [6];
    logic signed [31:0] r1_sq [4];
    logic signed [31:0] r1_cr [6];
    t_pos               r1_pos;

    always_comb begin
        n1_sq[0] = i_quat_w * i_quat_w;
        n1_sq[1] = i_quat_x * i_quat_x;
        n1_sq[2] = i_quat_y * i_quat_y;
        n1_sq[3] = i_quat_z * i_quat_z;
        n1_cr[0] = i_quat_x * i_quat_y;
        n1_cr[1] = i_quat_w * i_quat_z;
        n1_cr[2] = i_quat_x * i_quat_z;
        n1_cr[3] = i_quat_w * i_quat_y;
        n1_cr[4] = i_quat_y * i_quat_z;
        n1_cr[5] = i_quat_w * i_quat_x;
    end

    always_ff @(posedge i_clk) begin
        r1_sq <= n1_sq;
        r1_cr <= n1_cr;
        r1_pos.mk[0] <= i_marker_x;
        r1_pos.mk[1] <= i_marker_y;
        r1_pos.mk[2] <= i_marker_z;
        r1_pos.tg[0] <= i_target_x;
        r1_pos.tg[1] <= i_target_y;
        r1_pos.tg[2] <= i_target_z;
    end

    // ------------------------------------------------------------------
    // stage 2: norm and matrix numerators
    // ------------------------------------------------------------------
    logic [32:0]        n2_n;
    logic signed [33:0] n2_num [9];
    logic [32:0]        r2_n;
    logic signed [33:0] r2_num [9];
    t_pos               r2_pos;

    always_comb begin
        n2_n = 33'(r1_sq[0]) + 33'(r1_sq[1]) + 33'(r1_sq[2]) + 33'(r1_sq[3]);
        n2_num[0] = 34'(r1_sq[0]) + 34'(r1_sq[1]) - 34'(r1_sq[2]) - 34'(r1_sq[3]);
        n2_num[1] = (34'(r1_cr[0]) - 34'(r1_cr[1])) <<< 1;
        n2_num[2] = (34'(r1_cr[2]) + 34'(r1_cr[3])) <<< 1;
        n2_num[3] = (34'(r1_cr[0]) + 34'(r1_cr[1])) <<< 1;
        n2_num[4] = 34'(r1_sq[0]) - 34'(r1_sq[1]) + 34'(r1_sq[2]) - 34'(r1_sq[3]);
        n2_num[5] = (34'(r1_cr[4]) - 34'(r1_cr[5])) <<< 1;
        n2_num[6] = (34'(r1_cr[2]) - 34'(r1_cr[3])) <<< 1;
        n2_num[7] = (34'(r1_cr[4]) + 34'(r1_cr[5])) <<< 1;
        n2_num[8] = 34'(r1_sq[0]) - 34'(r1_sq[1]) - 34'(r1_sq[2]) + 34'(r1_sq[3]);
    end

    always_ff @(posedge i_clk) begin
        r2_n   <= n2_n;
        r2_num <= n2_num;
        r2_pos <= r1_pos;
    end

    // ------------------------------------------------------------------
    // stage 3: numerator magnitudes
    // ------------------------------------------------------------------
    logic [32:0] r3_mag [9];
    logic [8:0]  r3_neg;
    logic [32:0] r3_n;
    t_pos        r3_pos;

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 9; l++) begin
            r3_mag[l] <= r2_num[l][33] ? 33'(-r2_num[l]) : 33'(r2_num[l]);
            r3_neg[l] <= r2_num[l][33];
        end
        r3_n   <= r2_n;
        r3_pos <= r2_pos;
    end

    // ------------------------------------------------------------------
    // stage 4 and rotation divider: |num| * 2^30 / n, rounded
    // ------------------------------------------------------------------
    logic [32:0]          r_rd_rem  [0:ROT_STEPS][9];
    logic [ROT_STEPS-1:0] r_rd_low  [0:ROT_STEPS][9];
    logic [ROT_STEPS-1:0] r_rd_q    [0:ROT_STEPS][9];
    t_rot_side            r_rd_side [0:ROT_STEPS];
    logic [62:0]          n4_d      [9];

    always_comb begin
        for (int l = 0; l < 9; l++) begin
            n4_d[l] = {r3_mag[l], 30'd0} + 63'(r3_n >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 9; l++) begin
            r_rd_rem[0][l] <= {1'b0, n4_d[l][62:ROT_STEPS]};
            r_rd_low[0][l] <= n4_d[l][ROT_STEPS-1:0];
            r_rd_q[0][l]   <= '0;
        end
        r_rd_side[0].pos   <= r3_pos;
        r_rd_side[0].neg   <= r3_neg;
        r_rd_side[0].ident <= (r3_n == '0);
        r_rd_side[0].n     <= r3_n;
    end

    for (genvar k = 1; k <= ROT_STEPS; k++) begin : g_rdiv
        for (genvar l = 0; l < 9; l++) begin : g_lane
            logic [33:0] trial;
            logic [33:0] diff;
            assign trial = {r_rd_rem[k-1][l], r_rd_low[k-1][l][ROT_STEPS-1]};
            assign diff  = trial - 34'(r_rd_side[k-1].n);
            always_ff @(posedge i_clk) begin
                if (trial >= 34'(r_rd_side[k-1].n)) begin
                    r_rd_rem[k][l] <= diff[32:0];
                    r_rd_q[k][l]   <= {r_rd_q[k-1][l][ROT_STEPS-2:0], 1'b1};
                end else begin
                    r_rd_rem[k][l] <= trial[32:0];
                    r_rd_q[k][l]   <= {r_rd_q[k-1][l][ROT_STEPS-2:0], 1'b0};
                end
                r_rd_low[k][l] <= {r_rd_low[k-1][l][ROT_STEPS-2:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            r_rd_side[k] <= r_rd_side[k-1];
        end
    end

    // ------------------------------------------------------------------
    // rotation matrix, products with offset, sum, rounding
    // ------------------------------------------------------------------
    logic signed [31:0] n_rm [9];
    logic signed [31:0] r_rm [9];
    t_pos               r_rm_pos;
    logic signed [62:0] r_prod [9];
    t_pos               r_prod_pos;
    logic signed [63:0] r_acc [3];
    t_pos               r_acc_pos;
    logic signed [33:0] r_rot [3];
    t_pos               r_rot_pos;

    always_comb begin
        for (int l = 0; l < 9; l++) begin
            if (r_rd_side[ROT_STEPS].ident) begin
                // zero quaternion: identity
                n_rm[l] = (l % 4 == 0) ? Q30_ONE : '0;
            end else if (r_rd_side[ROT_STEPS].neg[l]) begin
                n_rm[l] = -32'(r_rd_q[ROT_STEPS][l]);
            end else begin
                n_rm[l] = 32'(r_rd_q[ROT_STEPS][l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rm     <= n_rm;
        r_rm_pos <= r_rd_side[ROT_STEPS].pos;
        for (int l = 0; l < 9; l++) begin
            r_prod[l] <= r_rm[l] * r_off[l % 3];
        end
        r_prod_pos <= r_rm_pos;
        for (int i = 0; i < 3; i++) begin
            r_acc[i] <= 64'(r_prod[3*i]) + 64'(r_prod[3*i+1]) + 64'(r_prod[3*i+2]);
        end
        r_acc_pos <= r_prod_pos;
        // half away from zero: negative values take one less of bias
        for (int i = 0; i < 3; i++) begin
            r_rot[i] <= 34'((r_acc[i] + (r_acc[i][63] ? 64'sh1FFF_FFFF : 64'sh2000_0000))
                            >>> 30);
        end
        r_rot_pos <= r_acc_pos;
    end

    // ------------------------------------------------------------------
    // error, gain, speed test
    // ------------------------------------------------------------------
    logic signed [34:0] r_err [3];
    logic [33:0]        r_emag [3];
    logic [2:0]         r_eneg;
    logic [49:0]        r_phi [3];
    logic [49:0]        r_plo [3];
    logic [2:0]         r_p_neg;
    logic [50:0]        r_s [3];
    logic [2:0]         r_s_neg;
    logic [50:0]        n_mx;
    logic [50:0]        r_q_mx;
    logic [50:0]        r_q_s [3];
    logic [2:0]         r_q_neg;
    logic [63:0]        r_q_sq [3];
    logic [63:0]        r_q_capsq;
    logic [50:0]        r_c_mx;
    logic [50:0]        r_c_s [3];
    t_tail              r_c_tail;

    always_comb begin
        n_mx = r_s[0];
        if (r_s[1] > n_mx) n_mx = r_s[1];
        if (r_s[2] > n_mx) n_mx = r_s[2];
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_err[i] <= 35'(signed'(r_rot_pos.tg[i])) - 35'(signed'(r_rot_pos.mk[i]))
                      - 35'(r_rot[i]);
            r_emag[i] <= r_err[i][34] ? 34'(-r_err[i]) : 34'(r_err[i]);
            r_eneg[i] <= r_err[i][34];
            r_phi[i]  <= 50'(r_emag[i]) * 50'(r_gain[31:16]);
            r_plo[i]  <= 50'(r_emag[i]) * 50'(r_gain[15:0]);
            r_s[i]    <= 51'(r_phi[i]) + ((51'(r_plo[i]) + 51'(16'h8000)) >> 16);
            r_q_s[i]  <= r_s[i];
            r_q_sq[i] <= 64'(r_s[i][31:0]) * 64'(r_s[i][31:0]);
            r_c_s[i]  <= r_q_s[i];
            r_c_tail.s32[i] <= r_q_s[i][31:0];
        end
        r_p_neg   <= r_eneg;
        r_s_neg   <= r_p_neg;
        r_q_neg   <= r_s_neg;
        r_q_mx    <= n_mx;
        r_q_capsq <= 64'(r_cap) * 64'(r_cap);
        r_c_mx    <= r_q_mx;
        r_c_tail.neg <= r_q_neg;
        // squares only mean something when no component is above the cap
        r_c_tail.capped <= (r_q_mx > 51'(r_cap))
                        || ((66'(r_q_sq[0]) + 66'(r_q_sq[1]) + 66'(r_q_sq[2]))
                            > 66'(r_q_capsq));
    end

    // ------------------------------------------------------------------
    // normalize so the largest component lies in [2^30, 2^31)
    // ------------------------------------------------------------------
    logic [50:0] n1_mx;
    logic [50:0] n1_s [3];
    logic [50:0] r_n1_mx;
    logic [50:0] r_n1_s [3];
    t_tail       r_n1_tail;
    logic [50:0] n2_mx;
    logic [50:0] n2_s [3];
    logic [30:0] r_n2_r [3];
    t_tail       r_n2_tail;

    always_comb begin
        n1_mx = r_c_mx;
        n1_s  = r_c_s;
        if (n1_mx[50:19] == '0) begin
            n1_mx = n1_mx << 32;
            for (int i = 0; i < 3; i++) n1_s[i] = n1_s[i] << 32;
        end
        if (n1_mx[50:35] == '0) begin
            n1_mx = n1_mx << 16;
            for (int i = 0; i < 3; i++) n1_s[i] = n1_s[i] << 16;
        end
        if (n1_mx[50:43] == '0) begin
            n1_mx = n1_mx << 8;
            for (int i = 0; i < 3; i++) n1_s[i] = n1_s[i] << 8;
        end
    end

    always_comb begin
        n2_mx = r_n1_mx;
        n2_s  = r_n1_s;
        if (n2_mx[50:47] == '0) begin
            n2_mx = n2_mx << 4;
            for (int i = 0; i < 3; i++) n2_s[i] = n2_s[i] << 4;
        end
        if (n2_mx[50:49] == '0) begin
            n2_mx = n2_mx << 2;
            for (int i = 0; i < 3; i++) n2_s[i] = n2_s[i] << 2;
        end
        if (!n2_mx[50]) begin
            n2_mx = n2_mx << 1;
            for (int i = 0; i < 3; i++) n2_s[i] = n2_s[i] << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n1_mx   <= n1_mx;
        r_n1_s    <= n1_s;
        r_n1_tail <= r_c_tail;
        for (int i = 0; i < 3; i++) begin
            r_n2_r[i] <= n2_s[i][50:20];
        end
        r_n2_tail <= r_n1_tail;
    end

    // ------------------------------------------------------------------
    // sum of squares and square root
    // ------------------------------------------------------------------
    logic [61:0]           r_rsq [3];
    t_sq_side              r_rsq_side;
    logic [63:0]           r_sq_x    [0:SQRT_STEPS];
    logic [33:0]           r_sq_rem  [0:SQRT_STEPS];
    logic [SQRT_STEPS-1:0] r_sq_root [0:SQRT_STEPS];
    t_sq_side              r_sq_side [0:SQRT_STEPS];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_rsq[i]        <= 62'(r_n2_r[i]) * 62'(r_n2_r[i]);
            r_rsq_side.r[i] <= r_n2_r[i];
        end
        r_rsq_side.tail <= r_n2_tail;
        r_sq_x[0]    <= 64'(r_rsq[0]) + 64'(r_rsq[1]) + 64'(r_rsq[2]);
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
        r_sq_side[0] <= r_rsq_side;
    end

    for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
        logic [35:0] shifted;
        logic [35:0] trial;
        logic [35:0] diff;
        assign shifted = {r_sq_rem[k-1], r_sq_x[k-1][63:62]};
        assign trial   = 36'({r_sq_root[k-1], 2'b01});
        assign diff    = shifted - trial;
        always_ff @(posedge i_clk) begin
            if (shifted >= trial) begin
                r_sq_rem[k]  <= diff[33:0];
                r_sq_root[k] <= {r_sq_root[k-1][SQRT_STEPS-2:0], 1'b1};
            end else begin
                r_sq_rem[k]  <= shifted[33:0];
                r_sq_root[k] <= {r_sq_root[k-1][SQRT_STEPS-2:0], 1'b0};
            end
            r_sq_x[k]    <= {r_sq_x[k-1][61:0], 2'b00};
            r_sq_side[k] <= r_sq_side[k-1];
        end
    end

    // ------------------------------------------------------------------
    // rescale divider: (r * cap + m/2) / m
    // ------------------------------------------------------------------
    logic [62:0]          r_rc [3];
    t_cd_side             r_rc_side;
    logic [63:0]          n_cd_d [3];
    logic [31:0]          r_cd_rem  [0:CAP_STEPS][3];
    logic [CAP_STEPS-1:0] r_cd_low  [0:CAP_STEPS][3];
    logic [CAP_STEPS-1:0] r_cd_q    [0:CAP_STEPS][3];
    t_cd_side             r_cd_side [0:CAP_STEPS];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_cd_d[i] = 64'(r_rc[i]) + 64'(r_rc_side.m >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_rc[i] <= 63'(r_sq_side[SQRT_STEPS].r[i]) * 63'(r_cap);
            r_cd_rem[0][i] <= n_cd_d[i][63:CAP_STEPS];
            r_cd_low[0][i] <= n_cd_d[i][CAP_STEPS-1:0];
            r_cd_q[0][i]   <= '0;
        end
        r_rc_side.m    <= r_sq_root[SQRT_STEPS];
        r_rc_side.tail <= r_sq_side[SQRT_STEPS].tail;
        r_cd_side[0]   <= r_rc_side;
    end

    for (genvar k = 1; k <= CAP_STEPS; k++) begin : g_cdiv
        for (genvar i = 0; i < 3; i++) begin : g_lane
            logic [32:0] trial;
            logic [32:0] diff;
            assign trial = {r_cd_rem[k-1][i], r_cd_low[k-1][i][CAP_STEPS-1]};
            assign diff  = trial - 33'(r_cd_side[k-1].m);
            always_ff @(posedge i_clk) begin
                if (trial >= 33'(r_cd_side[k-1].m)) begin
                    r_cd_rem[k][i] <= diff[31:0];
                    r_cd_q[k][i]   <= {r_cd_q[k-1][i][CAP_STEPS-2:0], 1'b1};
                end else begin
                    r_cd_rem[k][i] <= trial[31:0];
                    r_cd_q[k][i]   <= {r_cd_q[k-1][i][CAP_STEPS-2:0], 1'b0};
                end
                r_cd_low[k][i] <= {r_cd_low[k-1][i][CAP_STEPS-2:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            r_cd_side[k] <= r_cd_side[k-1];
        end
    end

    // ------------------------------------------------------------------
    // output: pick, restore sign, saturate
    // ------------------------------------------------------------------
    logic [31:0]        n_mag [3];
    logic signed [31:0] n_vel [3];
    logic signed [31:0] r_vel [3];
    logic               r_capped;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = r_cd_side[CAP_STEPS].tail.capped ? r_cd_q[CAP_STEPS][i]
                                                        : r_cd_side[CAP_STEPS].tail.s32[i];
            if (r_cd_side[CAP_STEPS].tail.neg[i]) begin
                if (n_mag[i] > 32'h8000_0000) n_vel[i] = 32'sh8000_0000;
                else n_vel[i] = -signed'(n_mag[i]);
            end else begin
                if (n_mag[i] > 32'h7FFF_FFFF) n_vel[i] = 32'sh7FFF_FFFF;
                else n_vel[i] = signed'(n_mag[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vel    <= n_vel;
        r_capped <= r_cd_side[CAP_STEPS].tail.capped;
    end

    assign o_vel_x  = r_vel[0];
    assign o_vel_y  = r_vel[1];
    assign o_vel_z  = r_vel[2];
    assign o_capped = r_capped;

endmodule

### rtl/core/svc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svc_checker
// Port-level timing checks of the servo velocity unit, bound to the top.
// ----------------------------------------------------------------------------
`include "servo_velocity_with_speed_cap_unit_macros.svh"

module svc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic i_busy,
    input logic i_valid
);
    import svc_pkg::*;

    logic w_acc;

    assign w_acc = i_start && !i_busy;

    // every accepted item comes out after the fixed latency
    `SVC_ASSERT_DELAY(a_item_out, i_clk, i_rst_n, w_acc, LATENCY, i_valid, "item result lost")

    // no result without an item accepted the latency before
    `SVC_ASSERT_IMPL(a_no_stray, i_clk, i_rst_n, i_valid, $past(w_acc, LATENCY), "stray result")

    // no item can be taken while reset is applied
    `SVC_ASSERT_NEXT(a_busy_rst, i_clk, 1'b1, !i_rst_n, i_busy, "busy low in reset")

endmodule

bind servo_velocity_with_speed_cap_unit svc_checker u_svc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (start),
    .i_busy  (busy),
    .i_valid (o_valid)
);
